/* hdl/amr_pkg.sv */
// Package for the address multiplexer register block.
// Holds the item and result layouts, field masks, mode tables and state codes.
// Used by every module of the block; depends on nothing.
`default_nettype none

package amr_pkg;

    // Field widths of the stream items
    localparam int ACT_W     = 2;
    localparam int OFF_W     = 6;
    localparam int REG_W     = 16;
    localparam int LINE_W    = 9;
    localparam int MODE_W    = 3;
    localparam int HEIGHT_W  = 4;
    localparam int PITCH_W   = 6;
    localparam int IN_DATA_W = 48;
    localparam int OUT_W     = 40;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Control register fields
    localparam logic [REG_W-1:0] MODE_BITS   = 16'h0007;
    localparam logic [REG_W-1:0] OFFSET_BITS = 16'h03F8;
    localparam logic [REG_W-1:0] PAGE_BITS   = 16'h0400;
    localparam logic [REG_W-1:0] RATE_BITS   = 16'h1800;
    localparam logic [REG_W-1:0] SIZE_BITS   = 16'h6000;
    localparam logic [REG_W-1:0] MAP_BITS    = 16'h8000;
    localparam logic [REG_W-1:0] SIZE_4K     = 16'h0000;
    localparam logic [REG_W-1:0] SIZE_16K    = 16'h2000;
    localparam logic [REG_W-1:0] MASK_4K     = 16'h0FFF;
    localparam logic [REG_W-1:0] MASK_16K    = 16'h3FFF;
    localparam logic [OFF_W-1:0] WRITE_SPACE = 6'd32;
    localparam int               OFFSET_SHIFT = 6;

    // Input action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_LINE  = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    // Work kinds after classification
    typedef enum logic [1:0] {
        K_NONE = 2'd0,
        K_LOAD = 2'd1,
        K_LINE = 2'd2
    } t_kind;

    // Queue entry: bus writes inside WRITE_SPACE arrive here as one-bit masked loads
    typedef struct packed {
        t_kind             kind;
        logic [REG_W-1:0]  value;
        logic [REG_W-1:0]  mask;
        logic [LINE_W-1:0] line;
    } t_entry;

    // Result beat, lowest field in the lowest bits
    typedef struct packed {
        logic [3:0]       pad;
        logic             map_changed;
        logic             size_changed;
        logic             rate_changed;
        logic             page_changed;
        logic [REG_W-1:0] register_value;
        logic [REG_W-1:0] video_address;
    } t_result;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MOD  = 3'b010,
        S_DONE = 3'b100
    } t_bstate;

    // Scanlines per character row for each mode
    function automatic logic [HEIGHT_W-1:0] row_height(input logic [MODE_W-1:0] mode);
        logic [HEIGHT_W-1:0] h;
        case (mode)
            3'd0:    h = 4'd12;
            3'd1:    h = 4'd3;
            3'd2:    h = 4'd3;
            3'd3:    h = 4'd2;
            3'd4:    h = 4'd2;
            default: h = 4'd1;
        endcase
        return h;
    endfunction

    // Bytes per row for each mode
    function automatic logic [PITCH_W-1:0] row_pitch(input logic [MODE_W-1:0] mode);
        logic [PITCH_W-1:0] p;
        case (mode)
            3'd1:    p = 6'd16;
            3'd3:    p = 6'd16;
            3'd5:    p = 6'd16;
            default: p = 6'd32;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

/* hdl/amr_front.sv */
// Front end: takes input beats, decodes the action and registers a queue entry.
// Depends on amr_pkg.
`default_nettype none

module amr_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [amr_pkg::ACT_W-1:0]       i_action,
    input  wire logic [amr_pkg::IN_DATA_W-1:0]   i_data,
    output logic                                 o_push,
    output amr_pkg::t_entry                      o_entry,
    input  wire logic                            i_q_ready
);
    import amr_pkg::*;

    logic              r_valid;
    t_entry            r_entry;
    t_entry            n_entry;
    t_action           act;
    logic [OFF_W-1:0]  offset;
    logic [REG_W-1:0]  bit_sel;

    assign act     = t_action'(i_action);
    assign offset  = i_data[5:0];
    assign bit_sel = REG_W'(1) << offset[4:1];

    // Classify: bus writes inside WRITE_SPACE become one-bit masked loads, others K_NONE
    always_comb begin
        n_entry       = '0;
        n_entry.value = i_data[21:6];
        n_entry.mask  = i_data[37:22];
        n_entry.line  = i_data[46:38];
        case (act)
            ACT_WRITE: begin
                if (offset < WRITE_SPACE) begin
                    n_entry.kind  = K_LOAD;
                    n_entry.mask  = bit_sel;
                    n_entry.value = offset[0] ? bit_sel : '0;
                end else begin
                    n_entry.kind  = K_NONE;
                end
            end
            ACT_LOAD: n_entry.kind = K_LOAD;
            ACT_LINE: n_entry.kind = K_LINE;
            default:  n_entry.kind = K_NONE;
        endcase
    end

    assign o_ready = !r_valid || i_q_ready;
    assign o_push  = r_valid;
    assign o_entry = r_entry;

    // Holding register in front of the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_entry <= n_entry;
        end
    end

endmodule

`default_nettype wire

/* hdl/amr_queue.sv */
// Short FIFO of decoded entries between front end and back end.
// Depends on amr_pkg for the entry type.
`default_nettype none

module amr_queue #(
    parameter int DEPTH = amr_pkg::QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  amr_pkg::t_entry   i_entry,
    output logic              o_ready,
    output logic              o_valid,
    output amr_pkg::t_entry   o_entry,
    input  wire logic         i_pop
);
    import amr_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    t_entry            r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_ready = r_count != CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_entry = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST) ? '0 : r_rptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

/* hdl/amr_back.sv */
// Back end: owns the control register and video counter, runs the bit-serial
// row-height remainder for scanlines and fills the result register.
// Depends on amr_pkg.
`default_nettype none

module amr_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_valid,
    input  amr_pkg::t_entry                  i_q_entry,
    output logic                             o_pop,
    input  wire logic                        i_extended,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [amr_pkg::OUT_W-1:0]        o_data
);
    import amr_pkg::*;

    localparam int STEP_W = $clog2(LINE_W);

    t_bstate             r_state;
    t_entry              r_cur;
    logic [REG_W-1:0]    r_ctrl;
    logic [REG_W-1:0]    r_vc;
    logic [LINE_W-1:0]   r_prev;
    logic [HEIGHT_W-1:0] r_div;
    logic [HEIGHT_W-1:0] r_rem;
    logic [STEP_W-1:0]   r_step;
    logic                r_o_valid;
    t_result             r_o_data;

    logic [HEIGHT_W:0]   rem_shift;
    logic [HEIGHT_W:0]   rem_sub;
    logic [REG_W-1:0]    n_ctrl;
    logic [REG_W-1:0]    n_vc;
    logic [LINE_W-1:0]   n_prev;
    logic [REG_W-1:0]    diff;
    logic [REG_W-1:0]    addr;
    t_result             result;
    logic                slot_free;
    logic                commit;
    logic                needs_mod;

    assign slot_free = !r_o_valid || i_ready;
    assign commit    = (r_state == S_DONE) && slot_free;
    assign o_pop     = (r_state == S_IDLE) && i_q_valid;
    assign needs_mod = (i_q_entry.kind == K_LINE) && (i_q_entry.line != r_prev)
                       && (i_q_entry.line != '0);

    // One remainder step: shift in the next line bit, subtract if it fits
    assign rem_shift = {r_rem, r_cur.line[r_step]};
    assign rem_sub   = rem_shift - {1'b0, r_div};

    // Next state of the register file for the item being finished
    always_comb begin
        n_ctrl = r_ctrl;
        n_vc   = r_vc;
        n_prev = r_prev;
        case (r_cur.kind)
            K_LOAD: n_ctrl = (r_ctrl & ~r_cur.mask) | (r_cur.value & r_cur.mask);
            K_LINE: begin
                if (r_cur.line != r_prev) begin
                    if (r_cur.line == '0) begin
                        n_vc = (r_ctrl & OFFSET_BITS) << OFFSET_SHIFT;
                    end else if (r_rem == '0) begin
                        n_vc = r_vc + REG_W'(row_pitch(r_ctrl[MODE_W-1:0]));
                    end
                    n_prev = r_cur.line;
                end
            end
            default: n_ctrl = r_ctrl;
        endcase
    end

    // Address masking by memory size (outside extended mode) and change flags
    always_comb begin
        diff = r_ctrl ^ n_ctrl;
        addr = n_vc;
        if (!i_extended) begin
            if ((n_ctrl & SIZE_BITS) == SIZE_4K) begin
                addr = n_vc & MASK_4K;
            end else if ((n_ctrl & SIZE_BITS) == SIZE_16K) begin
                addr = n_vc & MASK_16K;
            end
        end
        result                = '0;
        result.video_address  = addr;
        result.register_value = n_ctrl;
        result.page_changed   = (diff & PAGE_BITS) != '0;
        result.rate_changed   = (diff & RATE_BITS) != '0;
        result.size_changed   = (diff & SIZE_BITS) != '0;
        result.map_changed    = (diff & MAP_BITS) != '0;
    end

    // Sequencer and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ctrl    <= '0;
            r_vc      <= '0;
            r_prev    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (commit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= needs_mod ? S_MOD : S_DONE;
                    end
                end
                S_MOD: begin
                    if (r_step == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (slot_free) begin
                        r_ctrl  <= n_ctrl;
                        r_vc    <= n_vc;
                        r_prev  <= n_prev;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers of the current item
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur  <= i_q_entry;
            r_rem  <= '0;
            r_step <= STEP_W'(LINE_W - 1);
            r_div  <= row_height(r_ctrl[MODE_W-1:0]);
        end else if (r_state == S_MOD) begin
            r_rem  <= rem_shift >= {1'b0, r_div} ? rem_sub[HEIGHT_W-1:0]
                                                 : rem_shift[HEIGHT_W-1:0];
            r_step <= r_step - STEP_W'(1);
        end
        if (commit) begin
            r_o_data <= result;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule

`default_nettype wire

/* hdl/address_multiplexer_registers_core.sv */
// Top level of the address multiplexer register block.
// Instantiates amr_front, amr_queue and amr_back; uses amr_pkg.
`default_nettype none

// Keeps the 16-bit control register and the video address counter and returns
// one result beat per input beat, in order. Input beats are decoded and
// registered and pass through a short queue, so the input side keeps taking
// beats while a result waits. From the queue head, a write, a load, a repeated
// line or line 0 goes from the idle state through the done state to the result
// register; any other scanline also passes the remainder state, which takes the
// line number modulo the row height one line bit per cycle. The extended_mode
// bit is written through the cfg channel, which is always ready.
module address_multiplexer_registers_core #(
    parameter int QUEUE_DEPTH = amr_pkg::QUEUE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Input stream
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // [5:0] bus_offset, [21:6] load_value, [37:22] load_mask, [46:38] line_number
    input  wire logic [amr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  wire logic [amr_pkg::ACT_W-1:0]      s_axis_tuser,
    // Result stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [15:0] video_address, [31:16] register_value, [32] page_changed,
    // [33] rate_changed, [34] size_changed, [35] map_changed
    output logic [amr_pkg::OUT_W-1:0]           m_axis_tdata,
    // Configuration: extended_mode
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic                           i_cfg_data
);
    import amr_pkg::*;

    logic   r_extended;
    logic   push;
    logic   q_ready;
    logic   q_valid;
    logic   pop;
    t_entry front_entry;
    t_entry q_entry;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_extended <= 1'b0;
        end else if (i_cfg_valid) begin
            r_extended <= i_cfg_data;
        end
    end

    amr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_action  (s_axis_tuser),
        .i_data    (s_axis_tdata),
        .o_push    (push),
        .o_entry   (front_entry),
        .i_q_ready (q_ready)
    );

    amr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .i_pop   (pop)
    );

    amr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_entry  (q_entry),
        .o_pop      (pop),
        .i_extended (r_extended),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata)
    );

endmodule

`default_nettype wire

/* hdl/amr_checker.sv */
// Port-level checker for the address multiplexer register block, bound to the
// top level. Depends on amr_pkg for widths and field masks.
`default_nettype none

module amr_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [amr_pkg::OUT_W-1:0]      m_axis_tdata,
    input wire logic                           i_cfg_valid,
    input wire logic                           o_cfg_ready,
    input wire logic                           i_cfg_data
);
    import amr_pkg::*;

    logic       r_ext;
    logic [3:0] r_inflight;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    // Shadow of extended_mode and count of beats still owed a result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext      <= 1'b0;
            r_inflight <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_ext <= i_cfg_data;
            end
            if (in_beat && !out_beat) begin
                r_inflight <= r_inflight + 4'd1;
            end else if (out_beat && !in_beat) begin
                r_inflight <= r_inflight - 4'd1;
            end
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_inflight != '0)
        else $error("result without an accepted item");

    a_size_4k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !r_ext && (m_axis_tdata[30:29] == 2'b00)
        |-> m_axis_tdata[15:12] == 4'd0)
        else $error("video address above 4K window");

    a_size_16k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !r_ext && (m_axis_tdata[30:29] == 2'b01)
        |-> m_axis_tdata[15:14] == 2'd0)
        else $error("video address above 16K window");

endmodule

bind address_multiplexer_registers_core amr_checker u_amr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready),
    .i_cfg_data    (i_cfg_data)
);

`default_nettype wire
